>>> rtl/core/fsx_pkg.sv
// Shared types and constants for the Forth stack executor.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package fsx_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DATA_W      = 32;
  localparam int LIT_W       = 31;
  localparam int FUNC_W      = 4;
  localparam int KIND_W      = 3;
  localparam int ERR_W       = 2;
  localparam int CNT_W       = $clog2(DATA_W + 1);

  localparam int IN_BITS     = FUNC_W + LIT_W;
  localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = DATA_W + ERR_W + 1;
  localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_DUP   = 4'd5,
    FN_EMIT  = 4'd6,
    FN_PRINT = 4'd7,
    FN_LIST  = 4'd8,
    FN_EXIT  = 4'd9
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KD_ACK   = 3'd0,
    KD_CHAR  = 3'd1,
    KD_NUM   = 3'd2,
    KD_ENTRY = 3'd3,
    KD_EMPTY = 3'd4
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ER_NONE  = 2'd0,
    ER_UNDER = 2'd1,
    ER_OVER  = 2'd2,
    ER_DIV0  = 2'd3
  } err_e;

  // Read address source for the stack memory.
  typedef enum logic [1:0] {
    RD_TOP  = 2'd0,
    RD_SEC  = 2'd1,
    RD_LIST = 2'd2
  } rd_sel_e;

  // Write data source for the stack memory.
  typedef enum logic [1:0] {
    WR_LIT  = 2'd0,
    WR_COPY = 2'd1,
    WR_ALU  = 2'd2,
    WR_QUOT = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    b_load;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    depth_inc;
    logic    depth_dec;
    logic    halt_set;
    logic    div_start;
    logic    idx_clr;
    logic    idx_inc;
    logic    out_load;
    kind_e   out_kind;
    err_e    out_err;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  halted;
    logic  depth_zero;
    logic  depth_lt2;
    logic  depth_full;
    logic  b_zero;
    logic  div_done;
    logic  out_free;
    logic  list_last;
  } sts_t;

endpackage

>>> rtl/core/fsx_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on fsx_pkg for widths.
`timescale 1ns / 1ps

module fsx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fsx_pkg::DATA_W-1:0] dividend_i,
  input  logic [fsx_pkg::DATA_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [fsx_pkg::DATA_W-1:0] quotient_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [fsx_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [fsx_pkg::DATA_W-1:0] rem_q, rem_d;
  logic [fsx_pkg::DATA_W-1:0] quo_q, quo_d;
  logic [fsx_pkg::DATA_W-1:0] dvs_q, dvs_d;
  logic                       neg_q, neg_d;
  logic [fsx_pkg::DATA_W:0]   shifted;
  logic [fsx_pkg::DATA_W+1:0] diff;

  assign shifted = {rem_q, quo_q[fsx_pkg::DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = fsx_pkg::CNT_W'(fsx_pkg::DATA_W);
      rem_d  = '0;
      quo_d  = dividend_i[fsx_pkg::DATA_W-1] ?
               (~dividend_i + fsx_pkg::DATA_W'(1)) : dividend_i;
      dvs_d  = divisor_i[fsx_pkg::DATA_W-1] ?
               (~divisor_i + fsx_pkg::DATA_W'(1)) : divisor_i;
      neg_d  = dividend_i[fsx_pkg::DATA_W-1] ^ divisor_i[fsx_pkg::DATA_W-1];
    end else if (busy_q) begin
      if (!diff[fsx_pkg::DATA_W+1]) begin
        rem_d = diff[fsx_pkg::DATA_W-1:0];
        quo_d = {quo_q[fsx_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[fsx_pkg::DATA_W-1:0];
        quo_d = {quo_q[fsx_pkg::DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - fsx_pkg::CNT_W'(1);
      if (cnt_q == fsx_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + fsx_pkg::DATA_W'(1)) : quo_q;

endmodule

>>> rtl/core/fsx_ctrl.sv
// Controller state machine of the Forth stack executor.
// Depends on fsx_pkg for the command and status structs.
`timescale 1ns / 1ps

module fsx_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsx_pkg::sts_t sts_i,
  output fsx_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_READ_B   = 8'b0000_0100,
    ST_READ_A   = 8'b0000_1000,
    ST_DIV      = 8'b0001_0000,
    ST_RESP     = 8'b0010_0000,
    ST_LIST_RD  = 8'b0100_0000,
    ST_LIST_OUT = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  fsx_pkg::kind_e        kind_q, kind_d;
  fsx_pkg::err_e         err_q, err_d;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    err_d   = err_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        kind_d  = fsx_pkg::KD_ACK;
        err_d   = fsx_pkg::ER_NONE;
        state_d = ST_RESP;
        if (!sts_i.halted) begin
          case (sts_i.func)
            fsx_pkg::FN_PUSH: begin
              if (sts_i.depth_full) begin
                err_d = fsx_pkg::ER_OVER;
              end else begin
                cmd_o.wr_en     = 1'b1;
                cmd_o.wr_sel    = fsx_pkg::WR_LIT;
                cmd_o.depth_inc = 1'b1;
              end
            end
            fsx_pkg::FN_ADD, fsx_pkg::FN_SUB, fsx_pkg::FN_MUL, fsx_pkg::FN_DIV: begin
              if (sts_i.depth_lt2) begin
                err_d = fsx_pkg::ER_UNDER;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = fsx_pkg::RD_TOP;
                state_d      = ST_READ_B;
              end
            end
            fsx_pkg::FN_DUP: begin
              if (sts_i.depth_zero) begin
                err_d = fsx_pkg::ER_UNDER;
              end else if (sts_i.depth_full) begin
                err_d = fsx_pkg::ER_OVER;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = fsx_pkg::RD_TOP;
                state_d      = ST_READ_B;
              end
            end
            fsx_pkg::FN_EMIT, fsx_pkg::FN_PRINT: begin
              if (sts_i.depth_zero) begin
                err_d = fsx_pkg::ER_UNDER;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = fsx_pkg::RD_TOP;
                state_d      = ST_READ_B;
              end
            end
            fsx_pkg::FN_LIST: begin
              if (sts_i.depth_zero) begin
                kind_d = fsx_pkg::KD_EMPTY;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = ST_LIST_RD;
              end
            end
            fsx_pkg::FN_EXIT: begin
              cmd_o.halt_set = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ_B: begin
        // The top entry is on the read port now.
        cmd_o.b_load = 1'b1;
        state_d      = ST_RESP;
        case (sts_i.func)
          fsx_pkg::FN_DUP: begin
            cmd_o.wr_en     = 1'b1;
            cmd_o.wr_sel    = fsx_pkg::WR_COPY;
            cmd_o.depth_inc = 1'b1;
          end
          fsx_pkg::FN_EMIT: begin
            cmd_o.depth_dec = 1'b1;
            kind_d          = fsx_pkg::KD_CHAR;
          end
          fsx_pkg::FN_PRINT: begin
            cmd_o.depth_dec = 1'b1;
            kind_d          = fsx_pkg::KD_NUM;
          end
          default: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = fsx_pkg::RD_SEC;
            state_d      = ST_READ_A;
          end
        endcase
      end
      ST_READ_A: begin
        state_d = ST_RESP;
        if (sts_i.func == fsx_pkg::FN_DIV) begin
          if (sts_i.b_zero) begin
            err_d = fsx_pkg::ER_DIV0;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end else begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = fsx_pkg::WR_ALU;
          cmd_o.depth_dec = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel    = fsx_pkg::WR_QUOT;
          cmd_o.depth_dec = 1'b1;
          state_d         = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd_o.out_kind = kind_q;
        cmd_o.out_err  = err_q;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_LIST_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = fsx_pkg::RD_LIST;
        state_d      = ST_LIST_OUT;
      end
      ST_LIST_OUT: begin
        cmd_o.out_kind = fsx_pkg::KD_ENTRY;
        cmd_o.out_err  = fsx_pkg::ER_NONE;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.list_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_LIST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= fsx_pkg::KD_ACK;
      err_q   <= fsx_pkg::ER_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      err_q   <= err_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> rtl/core/fsx_dp.sv
// Datapath of the Forth stack executor: stack memory, depth and halt state,
// operand register, arithmetic, divider and the output register.
// Depends on fsx_pkg and fsx_div.
`timescale 1ns / 1ps

module fsx_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fsx_pkg::S_TDATA_W-1:0] in_data_i,
  input  fsx_pkg::cmd_t                 cmd_i,
  output fsx_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsx_pkg::M_TDATA_W-1:0] out_data_o,
  output logic [fsx_pkg::KIND_W-1:0]    out_user_o,
  output logic                          out_last_o
);

  localparam int DW = fsx_pkg::DATA_W;
  localparam int AW = fsx_pkg::ADDR_W;
  localparam int PW = fsx_pkg::DEPTH_W;

  logic [DW-1:0]              mem [fsx_pkg::STACK_DEPTH];
  logic [DW-1:0]              rdata_q;
  logic [fsx_pkg::FUNC_W-1:0] func_q;
  logic [fsx_pkg::LIT_W-1:0]  lit_q;
  logic [PW-1:0]              depth_q, depth_d;
  logic                       halt_q, halt_d;
  logic [DW-1:0]              b_q;
  logic [AW-1:0]              idx_q;
  logic [PW-1:0]              depth_m1, depth_m2;
  logic [AW-1:0]              rd_addr, wr_addr;
  logic [DW-1:0]              wr_data, alu_res, div_quot, out_value;
  logic                       div_done;
  logic                       out_free, list_last;
  logic                       m_valid_q, m_valid_d;
  logic [fsx_pkg::KIND_W-1:0] m_kind_q;
  logic [DW-1:0]              m_value_q;
  logic [fsx_pkg::ERR_W-1:0]  m_err_q;
  logic                       m_halt_q, m_last_q;

  assign depth_m1  = depth_q - PW'(1);
  assign depth_m2  = depth_q - PW'(2);
  assign list_last = (PW'(idx_q) + PW'(1)) == depth_q;
  assign out_free  = !m_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      fsx_pkg::RD_TOP:  rd_addr = depth_m1[AW-1:0];
      fsx_pkg::RD_SEC:  rd_addr = depth_m2[AW-1:0];
      fsx_pkg::RD_LIST: rd_addr = idx_q;
      default:          rd_addr = depth_m1[AW-1:0];
    endcase
  end

  // Operand a is the second entry, on the read port; operand b is the top.
  always_comb begin
    case (fsx_pkg::func_e'(func_q))
      fsx_pkg::FN_ADD: alu_res = rdata_q + b_q;
      fsx_pkg::FN_SUB: alu_res = rdata_q - b_q;
      default:         alu_res = rdata_q * b_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      fsx_pkg::WR_LIT: begin
        wr_addr = depth_q[AW-1:0];
        wr_data = {1'b0, lit_q};
      end
      fsx_pkg::WR_COPY: begin
        wr_addr = depth_q[AW-1:0];
        wr_data = rdata_q;
      end
      fsx_pkg::WR_ALU: begin
        wr_addr = depth_m2[AW-1:0];
        wr_data = alu_res;
      end
      fsx_pkg::WR_QUOT: begin
        wr_addr = depth_m2[AW-1:0];
        wr_data = div_quot;
      end
      default: begin
        wr_addr = depth_q[AW-1:0];
        wr_data = rdata_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.out_kind)
      fsx_pkg::KD_CHAR:  out_value = {{(DW-8){1'b0}}, b_q[7:0]};
      fsx_pkg::KD_NUM:   out_value = b_q;
      fsx_pkg::KD_ENTRY: out_value = rdata_q;
      default:           out_value = '0;
    endcase
  end

  fsx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rdata_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.depth_inc) begin
      depth_d = depth_q + PW'(1);
    end else if (cmd_i.depth_dec) begin
      depth_d = depth_m1;
    end
    halt_d    = halt_q | cmd_i.halt_set;
    m_valid_d = m_valid_q;
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end else if (out_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      halt_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      depth_q   <= depth_d;
      halt_q    <= halt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      func_q <= in_data_i[fsx_pkg::FUNC_W-1:0];
      lit_q  <= in_data_i[fsx_pkg::IN_BITS-1:fsx_pkg::FUNC_W];
    end
    if (cmd_i.b_load) begin
      b_q <= rdata_q;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.out_load) begin
      m_kind_q  <= cmd_i.out_kind;
      m_value_q <= out_value;
      m_err_q   <= cmd_i.out_err;
      m_halt_q  <= halt_q;
      m_last_q  <= (cmd_i.out_kind == fsx_pkg::KD_ENTRY) ? list_last : 1'b1;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.func       = fsx_pkg::func_e'(func_q);
    sts_o.halted     = halt_q;
    sts_o.depth_zero = (depth_q == '0);
    sts_o.depth_lt2  = (depth_q < PW'(2));
    sts_o.depth_full = (depth_q >= PW'(fsx_pkg::STACK_DEPTH));
    sts_o.b_zero     = (b_q == '0);
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
    sts_o.list_last  = list_last;
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = fsx_pkg::M_TDATA_W'({m_halt_q, m_err_q, m_value_q});
  assign out_user_o  = m_kind_q;
  assign out_last_o  = m_last_q;

endmodule

>>> rtl/core/forth_stack_executor_top.sv
// Top level of the Forth stack executor: controller plus datapath.
// Depends on fsx_pkg, fsx_ctrl and fsx_dp (which holds fsx_div).
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tdata: func[3:0], literal[34:4], zero padding to 40 bits
// m_axis    out        tdata: value[31:0], error_code[33:32], halted[34], padding;
//                      tuser: kind; tlast: last result of the request
//
// Push, exit, halted requests, undefined codes and stack errors found at decode
// go from decode straight to the response; dup, emit and print first read the
// top entry; add, subtract, multiply and a divide by zero read both operands,
// one at a time, because each needs a read of the single memory read port.
// Divide then runs the divider, one quotient bit per cycle. List stack does one
// read and one output load per entry.
// Reset clears depth, halt, the controller and the output valid; the stack
// memory holds no reset value. A stalled output holds the controller in its
// output state, and a new request is taken only when the controller is idle.

module forth_stack_executor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // func (4), literal (31), from bit 0 up
  input  logic [fsx_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // value (32), error_code (2), halted (1), from bit 0 up
  output logic [fsx_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // kind (3)
  output logic [fsx_pkg::KIND_W-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  fsx_pkg::cmd_t cmd;
  fsx_pkg::sts_t sts;

  // The controller sequences each request through the memory reads, the
  // arithmetic unit or divider that it needs, and finally the output register.
  fsx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns all stack state and the registered output stage.
  fsx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef ASSERT_OFF
  // Only stack listings spread over several results.
  a_tlast_only_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o == fsx_pkg::KD_ENTRY))
    else $error("non-final result outside a stack listing");

  // Once exit has run, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.halted |=> sts.halted)
    else $error("halt flag dropped");

  // The output register is never overwritten while its result is still pending.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten");

  // Acknowledge and empty-listing results carry a zero value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == fsx_pkg::KD_ACK ||
                         m_axis_tuser_o == fsx_pkg::KD_EMPTY))
    |-> (m_axis_tdata_o[fsx_pkg::DATA_W-1:0] == '0))
    else $error("nonzero value on a result without data");
`endif

endmodule
